// File: src/pde_pkg.sv
// Shared constants, step codes and the command type of the palette delta packet encoder.
`default_nettype none
package pde_pkg;

  localparam int MAX_ENTRIES     = 256;
  localparam int IDX_W           = $clog2(MAX_ENTRIES + 1);
  localparam int OFF_W           = 10;
  localparam int BYTE_W          = 8;
  localparam int RUN_W           = 9;
  localparam int BYTES_PER_ENTRY = 3;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One bit per possible byte write of an item, in emit order.
  localparam int NSTEPS  = 8;
  localparam int STEP_W  = $clog2(NSTEPS);
  localparam logic [STEP_W-1:0] STEP_CLOSE_EARLY = 3'd0;
  localparam logic [STEP_W-1:0] STEP_SKIP        = 3'd1;
  localparam logic [STEP_W-1:0] STEP_RED         = 3'd2;
  localparam logic [STEP_W-1:0] STEP_GREEN       = 3'd3;
  localparam logic [STEP_W-1:0] STEP_BLUE        = 3'd4;
  localparam logic [STEP_W-1:0] STEP_CLOSE_LATE  = 3'd5;
  localparam logic [STEP_W-1:0] STEP_HDR_LO      = 3'd6;
  localparam logic [STEP_W-1:0] STEP_HDR_HI      = 3'd7;

  localparam logic [OFF_W-1:0] OFF_HDR_LO = 10'd0;
  localparam logic [OFF_W-1:0] OFF_HDR_HI = 10'd1;
  localparam logic [OFF_W-1:0] OFF_START  = 10'd2;

  typedef struct packed {
    logic [NSTEPS-1:0] mask;
    logic [OFF_W-1:0]  close_off;
    logic [BYTE_W-1:0] close_val;
    logic [OFF_W-1:0]  skip_off;
    logic [BYTE_W-1:0] skip_val;
    logic [OFF_W-1:0]  rgb_off;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] total;
  } pkt_cmd_t;

endpackage
`default_nettype wire

// File: src/pde_front.sv
// Front end: classifies each palette entry, keeps the run state, builds a write command.
`default_nettype none
module pde_front
  import pde_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic [BYTE_W-1:0] old_red,
  input  wire logic [BYTE_W-1:0] old_green,
  input  wire logic [BYTE_W-1:0] old_blue,
  input  wire logic [BYTE_W-1:0] new_red,
  input  wire logic [BYTE_W-1:0] new_green,
  input  wire logic [BYTE_W-1:0] new_blue,
  input  wire logic              final_entry,
  output logic                   cmd_valid,
  output pkt_cmd_t               cmd
);

  logic             in_change_run, in_change_run_next;
  logic [RUN_W-1:0] skip_run_length, skip_run_length_next;
  logic [RUN_W-1:0] change_run_length, change_run_length_next;
  logic [OFF_W-1:0] count_slot_offset, count_slot_offset_next;
  logic [OFF_W-1:0] next_offset, next_offset_next;
  logic [BYTE_W-1:0] packet_total, packet_total_next;
  logic [IDX_W-1:0] entry_index, entry_index_next;

  logic             same;
  logic             last;
  logic [IDX_W-1:0] idx_inc;
  logic [OFF_W-1:0] rgb_base;
  logic [RUN_W-1:0] chg_base;

  always_comb begin
    same    = (old_red == new_red) && (old_green == new_green) && (old_blue == new_blue);
    idx_inc = entry_index + 1'b1;
    last    = final_entry || (idx_inc >= IDX_W'(MAX_ENTRIES));

    in_change_run_next     = in_change_run;
    skip_run_length_next   = skip_run_length;
    change_run_length_next = change_run_length;
    count_slot_offset_next = count_slot_offset;
    next_offset_next       = next_offset;
    packet_total_next      = packet_total;
    entry_index_next       = idx_inc;
    rgb_base               = next_offset;
    chg_base               = change_run_length;

    cmd           = '0;
    cmd.skip_off  = next_offset;
    cmd.skip_val  = skip_run_length[BYTE_W-1:0];
    cmd.red       = new_red;
    cmd.green     = new_green;
    cmd.blue      = new_blue;

    if (same) begin
      if (in_change_run) begin
        // unchanged entry closes the open change run
        cmd.mask[STEP_CLOSE_EARLY] = 1'b1;
        cmd.close_off              = count_slot_offset;
        cmd.close_val              = change_run_length[BYTE_W-1:0];
        in_change_run_next         = 1'b0;
        skip_run_length_next       = RUN_W'(1);
      end else begin
        skip_run_length_next = skip_run_length + 1'b1;
      end
    end else begin
      if (!in_change_run) begin
        // open a packet: skip byte now, change-count slot reserved
        cmd.mask[STEP_SKIP]    = 1'b1;
        count_slot_offset_next = next_offset + 1'b1;
        rgb_base               = next_offset + OFF_W'(2);
        packet_total_next      = packet_total + 1'b1;
        in_change_run_next     = 1'b1;
        chg_base               = '0;
        skip_run_length_next   = '0;
      end
      cmd.mask[STEP_RED]     = 1'b1;
      cmd.mask[STEP_GREEN]   = 1'b1;
      cmd.mask[STEP_BLUE]    = 1'b1;
      next_offset_next       = rgb_base + OFF_W'(BYTES_PER_ENTRY);
      change_run_length_next = chg_base + 1'b1;
    end
    cmd.rgb_off = rgb_base;
    cmd.total   = packet_total_next;

    if (last) begin
      if (in_change_run_next) begin
        cmd.mask[STEP_CLOSE_LATE] = 1'b1;
        cmd.close_off             = count_slot_offset_next;
        cmd.close_val             = change_run_length_next[BYTE_W-1:0];
      end
      cmd.mask[STEP_HDR_LO]  = 1'b1;
      cmd.mask[STEP_HDR_HI]  = 1'b1;
      in_change_run_next     = 1'b0;
      skip_run_length_next   = '0;
      change_run_length_next = '0;
      count_slot_offset_next = '0;
      next_offset_next       = OFF_START;
      packet_total_next      = '0;
      entry_index_next       = '0;
    end

    // entries that write nothing are not queued
    cmd_valid = accept && (cmd.mask != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_change_run     <= 1'b0;
      skip_run_length   <= '0;
      change_run_length <= '0;
      count_slot_offset <= '0;
      next_offset       <= OFF_START;
      packet_total      <= '0;
      entry_index       <= '0;
    end else if (accept) begin
      in_change_run     <= in_change_run_next;
      skip_run_length   <= skip_run_length_next;
      change_run_length <= change_run_length_next;
      count_slot_offset <= count_slot_offset_next;
      next_offset       <= next_offset_next;
      packet_total      <= packet_total_next;
      entry_index       <= entry_index_next;
    end
  end

endmodule
`default_nettype wire

// File: src/pde_fifo.sv
// Short command queue between the front end and the write sequencer.
`default_nettype none
module pde_fifo
  import pde_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     wr,
  input  wire pkt_cmd_t wr_data,
  output logic          full,
  input  wire logic     rd,
  output pkt_cmd_t      rd_data,
  output logic          empty
);

  pkt_cmd_t            slots [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full    = (count == QCNT_W'(QDEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: src/pde_back.sv
// Back end: walks the head's write mask, one byte write per cycle while popped.
`default_nettype none
module pde_back
  import pde_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_empty,
  input  wire pkt_cmd_t      head,
  output logic               q_rd,
  input  wire logic          pop,
  output logic               empty,
  output logic [OFF_W-1:0]   write_offset,
  output logic [BYTE_W-1:0]  write_byte,
  output logic               done_res
);

  logic [NSTEPS-1:0] sent;
  logic [NSTEPS-1:0] pending;
  logic [NSTEPS-1:0] sel;
  logic [STEP_W-1:0] sel_idx;
  logic              out_valid;
  logic              advance;
  logic [OFF_W-1:0]  off_mux;
  logic [BYTE_W-1:0] byte_mux;

  always_comb begin
    pending = head.mask & ~sent;
    sel     = pending & (~pending + 1'b1);
    sel_idx = '0;
    for (int i = NSTEPS - 1; i >= 0; i--) begin
      if (pending[i]) begin
        sel_idx = STEP_W'(i);
      end
    end
    advance = !q_empty && (!out_valid || pop);
    q_rd    = advance && ((pending & ~sel) == '0);

    case (sel_idx)
      STEP_CLOSE_EARLY,
      STEP_CLOSE_LATE: begin
        off_mux  = head.close_off;
        byte_mux = head.close_val;
      end
      STEP_SKIP: begin
        off_mux  = head.skip_off;
        byte_mux = head.skip_val;
      end
      STEP_RED: begin
        off_mux  = head.rgb_off;
        byte_mux = head.red;
      end
      STEP_GREEN: begin
        off_mux  = head.rgb_off + OFF_W'(1);
        byte_mux = head.green;
      end
      STEP_BLUE: begin
        off_mux  = head.rgb_off + OFF_W'(2);
        byte_mux = head.blue;
      end
      STEP_HDR_LO: begin
        off_mux  = OFF_HDR_LO;
        byte_mux = head.total;
      end
      STEP_HDR_HI: begin
        off_mux  = OFF_HDR_HI;
        byte_mux = '0;
      end
      default: begin
        off_mux  = '0;
        byte_mux = '0;
      end
    endcase
  end

  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sent      <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        sent      <= q_rd ? '0 : (sent | sel);
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      write_offset <= off_mux;
      write_byte   <= byte_mux;
      done_res     <= (sel_idx == STEP_HDR_HI);
    end
  end

endmodule
`default_nettype wire

// File: src/palette_delta_packet_encoder.sv
// Top level of the palette delta packet encoder: front end, command queue, write sequencer.
`default_nettype none
// Palette delta packet encoder. Push one palette entry per item (old and new RGB, plus
// final_entry on the last entry; the 256th entry of a palette also ends it). Results come
// out as byte writes (write_offset, write_byte) that build a skip/change packet stream:
// a 16-bit little-endian packet count at offsets 0 and 1, then packets of skip byte,
// change-count byte and the new RGB bytes of each changed entry. The change-count byte
// is written when its run ends, so writes are not in address order; the header comes
// last, and done_res marks the header high byte, the final write of a palette. After it
// the next item starts a new palette. Rate: the back end issues one byte write per
// cycle while results are popped, and each entry makes writes as follows: none for an
// unchanged entry inside a skip run (the front end absorbs it and queues nothing), 1 for
// one that closes a change run, 3 or 4 for a changed entry, plus up to 3 on the final
// entry (7 at most). The front end classifies one entry per cycle, while the queue is
// not full, into a two-deep command queue, so input accepts continue while the back end
// drains earlier writes; full only rises when both queue slots hold pending commands.
module palette_delta_packet_encoder
  import pde_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [BYTE_W-1:0] old_red,
  input  wire logic [BYTE_W-1:0] old_green,
  input  wire logic [BYTE_W-1:0] old_blue,
  input  wire logic [BYTE_W-1:0] new_red,
  input  wire logic [BYTE_W-1:0] new_green,
  input  wire logic [BYTE_W-1:0] new_blue,
  input  wire logic              final_entry,
  output logic                   empty,
  input  wire logic              pop,
  output logic [OFF_W-1:0]       write_offset,
  output logic [BYTE_W-1:0]      write_byte,
  output logic                   done_res
);

  logic     accept;
  logic     cmd_valid;
  pkt_cmd_t cmd;
  pkt_cmd_t head;
  logic     q_empty;
  logic     q_rd;

  // entry taken whenever the queue has room, even if it produces no writes
  assign accept = push && !full;

  pde_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .old_red     (old_red),
    .old_green   (old_green),
    .old_blue    (old_blue),
    .new_red     (new_red),
    .new_green   (new_green),
    .new_blue    (new_blue),
    .final_entry (final_entry),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd)
  );

  pde_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (cmd_valid),
    .wr_data (cmd),
    .full    (full),
    .rd      (q_rd),
    .rd_data (head),
    .empty   (q_empty)
  );

  pde_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .head         (head),
    .q_rd         (q_rd),
    .pop          (pop),
    .empty        (empty),
    .write_offset (write_offset),
    .write_byte   (write_byte),
    .done_res     (done_res)
  );

`ifndef ASSERT_OFF
  // the last write of a palette is always the header high byte, zero
  a_done_is_hdr_hi: assert property (@(posedge clk) disable iff (rst)
    (!empty && done_res) |-> (write_offset == OFF_HDR_HI && write_byte == '0))
    else $error("done_res on a write other than the header high byte");

  // sequencer only retires a command that is present
  a_rd_not_empty: assert property (@(posedge clk) disable iff (rst)
    q_rd |-> !q_empty)
    else $error("command queue read while empty");

  // no write is presented right after reset
  a_empty_after_rst: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result shown right after reset");
`endif

endmodule
`default_nettype wire

// File: bench/palette_delta_packet_encoder_tb.sv
// Self-checking testbench for the palette delta packet encoder: directed and random palettes.
module palette_delta_packet_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pde_pkg::*;

  // Idle cycles with no accepted item on either side before the run is declared hung.
  // It lies well above the longest sender gap and the longest receiver stall that
  // pick_gap can choose.
  localparam int WATCHDOG_LIMIT = 1000;
  // Extra cycles after the last expected write, to catch stray writes.
  localparam int DRAIN_CYCLES   = 16;
  localparam int RANDOM_ITEMS   = 100;

  // One palette entry as pushed into the block.
  typedef struct packed {
    logic [BYTE_W-1:0] old_red;
    logic [BYTE_W-1:0] old_green;
    logic [BYTE_W-1:0] old_blue;
    logic [BYTE_W-1:0] new_red;
    logic [BYTE_W-1:0] new_green;
    logic [BYTE_W-1:0] new_blue;
    logic              final_entry;
  } palette_entry_t;

  // One byte write that the block should produce.
  typedef struct packed {
    logic [OFF_W-1:0]  offset;
    logic [BYTE_W-1:0] value;
    logic              last;
  } byte_write_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              push        = 1'b0;
  logic              full;
  logic [BYTE_W-1:0] old_red     = '0;
  logic [BYTE_W-1:0] old_green   = '0;
  logic [BYTE_W-1:0] old_blue    = '0;
  logic [BYTE_W-1:0] new_red     = '0;
  logic [BYTE_W-1:0] new_green   = '0;
  logic [BYTE_W-1:0] new_blue    = '0;
  logic              final_entry = 1'b0;
  logic              empty;
  logic              pop         = 1'b0;
  logic [OFF_W-1:0]  write_offset;
  logic [BYTE_W-1:0] write_byte;
  logic              done_res;

  palette_delta_packet_encoder u_top (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .old_red      (old_red),
    .old_green    (old_green),
    .old_blue     (old_blue),
    .new_red      (new_red),
    .new_green    (new_green),
    .new_blue     (new_blue),
    .final_entry  (final_entry),
    .empty        (empty),
    .pop          (pop),
    .write_offset (write_offset),
    .write_byte   (write_byte),
    .done_res     (done_res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Writes predicted but not yet seen on the result side, oldest first.
  byte_write_t pending_writes[$];
  byte_write_t oldest_write;
  int          err_count   = 0;
  int          idle_cycles = 0;
  int          pop_hold    = 0;
  int          pop_gap     = 0;
  // When set, neither side idles: back-to-back items and results.
  bit          steady      = 1'b0;

  // Encoder shadow state.
  logic              run_open;      // inside a run of changed entries
  logic [RUN_W-1:0]  skip_len;      // unchanged entries since the last packet
  logic [RUN_W-1:0]  change_len;    // changed entries in the open packet
  logic [OFF_W-1:0]  count_slot;    // where the open packet's change count goes
  logic [OFF_W-1:0]  write_ptr;     // next free byte of the packet stream
  logic [BYTE_W-1:0] packet_count;
  logic [IDX_W-1:0]  entry_count;   // entries seen in the current palette

  function automatic void clear_encoder();
    run_open     = 1'b0;
    skip_len     = '0;
    change_len   = '0;
    count_slot   = '0;
    write_ptr    = OFF_START;
    packet_count = '0;
    entry_count  = '0;
  endfunction

  function automatic void expect_write(input logic [OFF_W-1:0] off,
                                       input logic [BYTE_W-1:0] val, input logic last);
    byte_write_t w;
    w.offset = off;
    w.value  = val;
    w.last   = last;
    pending_writes.push_back(w);
  endfunction

  // Predict the byte writes of one accepted entry and advance the shadow state.
  function automatic void encode_entry(input palette_entry_t e);
    logic same;
    logic ends;
    same = (e.old_red == e.new_red) && (e.old_green == e.new_green) &&
           (e.old_blue == e.new_blue);
    entry_count = entry_count + 1'b1;
    // The MAX_ENTRIES-th entry closes the palette even without final_entry.
    ends = e.final_entry || (entry_count >= MAX_ENTRIES);
    if (same) begin
      if (run_open) begin
        // First unchanged entry after a change run: close its count now.
        expect_write(count_slot, change_len[BYTE_W-1:0], 1'b0);
        run_open = 1'b0;
        skip_len = RUN_W'(1);
      end else begin
        skip_len = skip_len + 1'b1;
      end
    end else begin
      if (!run_open) begin
        // Open a packet: skip byte now, change-count slot reserved behind it.
        expect_write(write_ptr, skip_len[BYTE_W-1:0], 1'b0);
        count_slot   = write_ptr + 1'b1;
        write_ptr    = write_ptr + 2'd2;
        packet_count = packet_count + 1'b1;
        run_open     = 1'b1;
        change_len   = '0;
        skip_len     = '0;
      end
      expect_write(write_ptr, e.new_red, 1'b0);
      write_ptr = write_ptr + 1'b1;
      expect_write(write_ptr, e.new_green, 1'b0);
      write_ptr = write_ptr + 1'b1;
      expect_write(write_ptr, e.new_blue, 1'b0);
      write_ptr = write_ptr + 1'b1;
      change_len = change_len + 1'b1;
    end
    if (ends) begin
      // Trailing unchanged entries write nothing; header goes last, high byte flagged.
      if (run_open) expect_write(count_slot, change_len[BYTE_W-1:0], 1'b0);
      expect_write(OFF_HDR_LO, packet_count, 1'b0);
      expect_write(OFF_HDR_HI, '0, 1'b1);
      clear_encoder();
    end
  endfunction

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Random entry; a changed entry differs in a random nonempty set of channels.
  function automatic palette_entry_t make_entry(input bit changed, input bit fin);
    palette_entry_t e;
    logic [2:0] sel;
    e.old_red   = BYTE_W'($urandom);
    e.old_green = BYTE_W'($urandom);
    e.old_blue  = BYTE_W'($urandom);
    e.new_red   = e.old_red;
    e.new_green = e.old_green;
    e.new_blue  = e.old_blue;
    if (changed) begin
      sel = 3'($urandom_range(1, 7));
      if (sel[0]) e.new_red   = BYTE_W'($urandom);
      if (sel[1]) e.new_green = BYTE_W'($urandom);
      if (sel[2]) e.new_blue  = BYTE_W'($urandom);
      if (e.new_red == e.old_red && e.new_green == e.old_green && e.new_blue == e.old_blue)
        e.new_red = ~e.old_red;
    end
    e.final_entry = fin;
    return e;
  endfunction

  // Push one entry; push stays high into the next item when there is no gap, so
  // it is never lowered and raised within one step.
  task automatic send_entry(input palette_entry_t e);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push        <= 1'b1;
    old_red     <= e.old_red;
    old_green   <= e.old_green;
    old_blue    <= e.old_blue;
    new_red     <= e.new_red;
    new_green   <= e.new_green;
    new_blue    <= e.new_blue;
    final_entry <= e.final_entry;
    @(posedge clk);
    // full read right after the edge is the value the block sampled at it
    while (full) @(posedge clk);
    encode_entry(e);
  endtask

  // Result side: random pop stalls, each accepted write checked against the oldest
  // prediction.
  always @(posedge clk) begin
    if (rst) begin
      pop      <= 1'b0;
      pop_hold <= 0;
    end else begin
      if (pop && !empty) begin
        if (pending_writes.size() == 0) begin
          $error("unexpected write: offset %0d byte %0d done %0d",
                 write_offset, write_byte, done_res);
          err_count++;
        end else begin
          oldest_write = pending_writes.pop_front();
          if (write_offset !== oldest_write.offset) begin
            $error("write_offset: expected %0d, got %0d", oldest_write.offset, write_offset);
            err_count++;
          end
          if (write_byte !== oldest_write.value) begin
            $error("write_byte: expected %0d, got %0d", oldest_write.value, write_byte);
            err_count++;
          end
          if (done_res !== oldest_write.last) begin
            $error("done_res: expected %0d, got %0d", oldest_write.last, done_res);
            err_count++;
          end
        end
      end
      if (pop_hold > 0) begin
        pop      <= 1'b0;
        pop_hold <= pop_hold - 1;
      end else if (pop && !empty) begin
        // after each accepted write, maybe stall for a while
        pop_gap = pick_gap();
        pop      <= (pop_gap == 0);
        pop_hold <= (pop_gap > 0) ? pop_gap - 1 : 0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Hang detection: cycles in a row with no item accepted on either side.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** palette_delta_packet_encoder: FAILED **");
      $finish;
    end
  end

  // Palette with no change at all: only the header, count zero.
  task automatic test_unchanged_palette();
    send_entry(make_entry(1'b0, 1'b0));
    send_entry(make_entry(1'b0, 1'b0));
    send_entry(make_entry(1'b0, 1'b1));
  endtask

  // One-entry palettes, changed and unchanged.
  task automatic test_single_entry_palettes();
    send_entry(make_entry(1'b1, 1'b1));
    send_entry(make_entry(1'b0, 1'b1));
  endtask

  // Field extremes: one channel differing at a time, then unchanged entries and all three
  // channels differing. Order of a literal: old R, G, B, new R, G, B, final.
  task automatic test_channel_extremes();
    send_entry('{8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 1'b0});
    send_entry('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 1'b0});
    send_entry('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b0});
    send_entry('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0});
    send_entry('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0});
    send_entry('{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0});
    send_entry('{8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1});
  endtask

  // Change run closed by an unchanged entry, a second packet, and a trailing skip
  // run that must leave no bytes behind.
  task automatic test_run_boundaries();
    send_entry(make_entry(1'b1, 1'b0));
    send_entry(make_entry(1'b0, 1'b0));
    send_entry(make_entry(1'b0, 1'b0));
    send_entry(make_entry(1'b1, 1'b0));
    send_entry(make_entry(1'b1, 1'b0));
    send_entry(make_entry(1'b0, 1'b0));
    send_entry(make_entry(1'b0, 1'b1));
  endtask

  // Full-length palette, all changed, no final flag: the change count of 256 is
  // stored as 0 and the last entry ends the palette. Runs with no idling.
  task automatic test_change_count_wrap();
    steady = 1'b1;
    for (int i = 0; i < MAX_ENTRIES; i++) send_entry(make_entry(1'b1, 1'b0));
    steady = 1'b0;
  endtask

  // Longest skip run, then a change on the entry that ends the palette by length.
  task automatic test_long_skip_run();
    for (int i = 0; i < MAX_ENTRIES - 1; i++) send_entry(make_entry(1'b0, 1'b0));
    send_entry(make_entry(1'b1, 1'b0));
  endtask

  // Random palettes: mostly short, each with its own change density; now and then
  // an early final flag or a missing one, so palettes split or merge.
  task automatic test_random_palettes();
    int sent;
    int len;
    int density;
    bit fin;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      len     = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
      density = $urandom_range(0, 100);
      steady  = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) begin
        if (i == len - 1) fin = ($urandom_range(0, 9) != 0);
        else fin = ($urandom_range(0, 31) == 0);
        send_entry(make_entry($urandom_range(0, 99) < density, fin));
      end
      sent += len;
    end
    steady = 1'b0;
  endtask

  initial begin
    clear_encoder();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_unchanged_palette();
    test_single_entry_palettes();
    test_channel_extremes();
    test_run_boundaries();
    test_change_count_wrap();
    test_long_skip_run();
    test_random_palettes();
    push <= 1'b0;

    // Let every predicted write come out, then watch a little longer for strays.
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_writes.size() != 0) begin
      $error("%0d predicted writes never arrived", pending_writes.size());
      err_count++;
    end

    if (err_count == 0) begin
      $display("** palette_delta_packet_encoder: PASSED **");
    end else begin
      $display("** palette_delta_packet_encoder: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
src/pde_pkg.sv
src/pde_front.sv
src/pde_fifo.sv
src/pde_back.sv
src/palette_delta_packet_encoder.sv
bench/palette_delta_packet_encoder_tb.sv
